// ----- design/anneal_acceptance_unit_top_macros.svh -----
`ifndef ANNEAL_ACCEPTANCE_UNIT_TOP_MACROS_SVH
`define ANNEAL_ACCEPTANCE_UNIT_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define AAU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("anneal acceptance unit assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define AAU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("anneal acceptance unit assertion failed");

`endif

// ----- design/aau_pkg.sv -----
package aau_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned RND_W       = 16;
  localparam int unsigned COOL_W      = 17;
  localparam int unsigned HEAT_W      = 24;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned EXP_SPAN    = 16;
  localparam int unsigned SPAN_SHIFT  = 4;
  localparam int unsigned PROB_W      = 17;
  localparam int unsigned PROD_W      = DATA_W + HEAT_W;

  typedef enum logic [1:0] {
    MODE_ANNEAL,
    MODE_THRESHOLD,
    MODE_OLD_BACHELOR,
    MODE_DELUGE
  } mode_t;

  localparam logic [CFG_INDEX_W-1:0] REG_POLICY_MODE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_TEMP = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COOLING      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HEATING      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_TEMP     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DELUGE_DECAY = 3'd5;

  localparam logic [DATA_W-1:0] RST_INITIAL_TEMP = 32'd25600;
  localparam logic [COOL_W-1:0] RST_COOLING      = 17'd64880;
  localparam logic [HEAT_W-1:0] RST_HEATING      = 24'd72090;
  localparam logic [DATA_W-1:0] RST_MAX_TEMP     = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] RST_DELUGE_DECAY = 32'd256;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_step;
    logic mul;
    logic write;
    logic out_load;
  } aau_cmd_t;

  typedef struct packed {
    logic need_div;
  } aau_status_t;

endpackage

// ----- design/aau_ctrl.sv -----
module aau_ctrl #(
  parameter int unsigned DIV_STEPS = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  aau_pkg::aau_status_t status,
  output aau_pkg::aau_cmd_t    cmd
);
  import aau_pkg::*;

  localparam int unsigned CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_MUL,
    ST_WRITE,
    ST_HOLD
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && in_valid;
    cmd.eval     = (state_r == ST_EVAL);
    cmd.div_step = (state_r == ST_DIV);
    cmd.mul      = (state_r == ST_MUL);
    cmd.write    = (state_r == ST_WRITE);
    cmd.out_load = (state_r == ST_HOLD) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        state_nxt = status.need_div ? ST_DIV : ST_MUL;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (cmd.out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- design/aau_datapath.sv -----
module aau_datapath #(
  parameter int unsigned FRACTION_BITS   = 8,
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_write_en,
  input  logic [aau_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [aau_pkg::DATA_W-1:0]              cfg_data,
  input  logic [aau_pkg::DATA_W-1:0]              in_current_cost,
  input  logic [aau_pkg::DATA_W-1:0]              in_previous_cost,
  input  logic [aau_pkg::RND_W-1:0]               in_random_value,
  input  aau_pkg::aau_cmd_t                       cmd,
  output aau_pkg::aau_status_t                    status,
  output logic                                    out_accepted,
  output logic [aau_pkg::DATA_W-1:0]              out_temperature_out
);
  import aau_pkg::*;

  localparam int unsigned IW    = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned NUM_W = DATA_W + IW;
  localparam int unsigned DIV_W = DATA_W + SPAN_SHIFT;
  localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRACTION_BITS;

  typedef logic [PROB_W-1:0] rom_t [EXP_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] a;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] e;
    a    = (64'(EXP_SPAN) << 30) / 64'(EXP_TABLE_DEPTH);
    sum  = 64'(1) << 30;
    term = sum;
    e    = sum;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * a) >> 30) / 64'(n);
      if (n[0]) begin
        sum = (sum >= term) ? sum - term : 64'(0);
      end else begin
        sum = sum + term;
      end
    end
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      rom[i] = PROB_W'((e + (64'(1) << 13)) >> 14);
      e      = (e * sum + (64'(1) << 29)) >> 30;
    end
    return rom;
  endfunction

  localparam rom_t EXP_ROM = build_rom();

  // configuration
  mode_t              mode_r;
  logic [DATA_W-1:0]  init_r;
  logic [COOL_W-1:0]  cool_r;
  logic [HEAT_W-1:0]  heat_r;
  logic [DATA_W-1:0]  max_r;
  logic [DATA_W-1:0]  decay_r;
  logic [DATA_W-1:0]  temp_r;

  // item
  logic [DATA_W-1:0]  cur_r;
  logic [DATA_W-1:0]  prev_r;
  logic [RND_W-1:0]   rnd_r;
  logic               acc_r;
  logic               zero_r;
  logic               div_r;
  logic [NUM_W-1:0]   num_r;
  logic [DIV_W-1:0]   rem_r;
  logic [IW-1:0]      q_r;
  logic [PROD_W-1:0]  prod_r;
  logic               out_acc_r;
  logic [DATA_W-1:0]  out_temp_r;

  // evaluation
  logic [DATA_W:0]    bound;
  logic               le, le_t, lt_t, big, t_zero;
  logic [DATA_W-1:0]  delta;
  logic [DIV_W-1:0]   div_d;
  logic               acc_eval;

  assign bound  = {1'b0, prev_r} + {1'b0, temp_r};
  assign le     = (cur_r <= prev_r);
  assign le_t   = ({1'b0, cur_r} <= bound);
  assign lt_t   = ({1'b0, cur_r} < bound);
  assign delta  = cur_r - prev_r;
  assign div_d  = DIV_W'(temp_r) << SPAN_SHIFT;
  assign big    = (DIV_W'(delta) >= div_d);
  assign t_zero = (temp_r == '0);

  assign status.need_div = (mode_r == MODE_ANNEAL) && !t_zero && !le && !big;

  always_comb begin
    case (mode_r)
      MODE_ANNEAL:    acc_eval = le;
      MODE_THRESHOLD: acc_eval = le_t;
      default:        acc_eval = lt_t;
    endcase
  end

  // restoring division, one quotient bit per step
  logic [DIV_W:0]     rem_sh;
  logic               rem_ge;
  logic [DIV_W:0]     rem_sub;

  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, div_d});
  assign rem_sub = rem_sh - {1'b0, div_d};

  // shared multiplier
  logic [DATA_W-1:0]  mul_a;
  logic [HEAT_W-1:0]  mul_b;
  logic [DATA_W-1:0]  start_t;

  assign start_t = (init_r > ONE_Q) ? init_r : ONE_Q;

  always_comb begin
    mul_a = ((mode_r == MODE_ANNEAL) && zero_r) ? start_t : temp_r;
    mul_b = ((mode_r == MODE_OLD_BACHELOR) && !acc_r) ? heat_r : HEAT_W'(cool_r);
  end

  // temperature update
  logic [DATA_W-1:0]  scaled;
  logic [DATA_W-1:0]  temp_nxt;

  assign scaled = (|prod_r[PROD_W-1:DATA_W+16]) ? '1 : prod_r[DATA_W+15:16];

  always_comb begin
    case (mode_r)
      MODE_ANNEAL: begin
        temp_nxt = (zero_r && (scaled == '0)) ? DATA_W'(1) : scaled;
      end
      MODE_THRESHOLD: begin
        temp_nxt = scaled;
      end
      MODE_OLD_BACHELOR: begin
        temp_nxt = (acc_r || (scaled < max_r)) ? scaled : max_r;
      end
      default: begin
        if (!acc_r) begin
          temp_nxt = temp_r;
        end else begin
          temp_nxt = (temp_r > decay_r) ? temp_r - decay_r : '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_ANNEAL;
      init_r  <= RST_INITIAL_TEMP;
      cool_r  <= RST_COOLING;
      heat_r  <= RST_HEATING;
      max_r   <= RST_MAX_TEMP;
      decay_r <= RST_DELUGE_DECAY;
      temp_r  <= RST_INITIAL_TEMP;
    end else begin
      if (cmd.write) begin
        temp_r <= temp_nxt;
      end
      if (cfg_write_en) begin
        case (cfg_index)
          REG_POLICY_MODE:  mode_r  <= mode_t'(cfg_data[1:0]);
          REG_INITIAL_TEMP: begin
            init_r <= cfg_data;
            temp_r <= cfg_data;
          end
          REG_COOLING:      cool_r  <= cfg_data[COOL_W-1:0];
          REG_HEATING:      heat_r  <= cfg_data[HEAT_W-1:0];
          REG_MAX_TEMP:     max_r   <= cfg_data;
          REG_DELUGE_DECAY: decay_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r  <= in_current_cost;
      prev_r <= in_previous_cost;
      rnd_r  <= in_random_value;
    end
    if (cmd.eval) begin
      acc_r  <= acc_eval;
      zero_r <= t_zero;
      div_r  <= status.need_div;
      num_r  <= NUM_W'(delta) * NUM_W'(EXP_TABLE_DEPTH);
      rem_r  <= '0;
      q_r    <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? DIV_W'(rem_sub) : DIV_W'(rem_sh);
      num_r <= num_r << 1;
      q_r   <= (q_r << 1) | IW'(rem_ge);
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
      if (div_r) begin
        acc_r <= ({1'b0, rnd_r} < EXP_ROM[q_r]);
      end
    end
    if (cmd.out_load) begin
      out_acc_r  <= acc_r;
      out_temp_r <= temp_r;
    end
  end

  assign out_accepted        = out_acc_r;
  assign out_temperature_out = out_temp_r;

endmodule

// ----- design/anneal_acceptance_unit_top.sv -----
// Acceptance decision for a local search: one result per input transfer, carrying the
// accept bit and the temperature (or water level) that holds after the step. The block
// takes one item at a time; a finished result sits in the output register while the next
// item is taken. An item passes the load, evaluate, multiply, write and hold states; when
// annealing mode meets a cost rise below 16 times a nonzero temperature, restoring
// division steps come between evaluate and multiply, since the index into the probability
// table comes from a divider that produces one quotient bit per cycle. A result that is
// still waiting on the output stalls the next one until out_ready takes it. Configuration
// must be written through the cfg_ port only while no item is in flight; the block does
// not enforce it. Writing the initial temperature also loads the running temperature.
`include "anneal_acceptance_unit_top_macros.svh"

module anneal_acceptance_unit_top #(
  parameter int unsigned FRACTION_BITS   = 8,
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_write_en,
  input  logic [aau_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [aau_pkg::DATA_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [aau_pkg::DATA_W-1:0]        in_current_cost,
  input  logic [aau_pkg::DATA_W-1:0]        in_previous_cost,
  input  logic [aau_pkg::RND_W-1:0]         in_random_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_accepted,
  output logic [aau_pkg::DATA_W-1:0]        out_temperature_out
);
  import aau_pkg::*;

  localparam int unsigned DIV_STEPS = DATA_W + $clog2(EXP_TABLE_DEPTH);

  aau_cmd_t                   cmd;
  aau_status_t                status;
  logic [$bits(aau_cmd_t)-1:0] cmd_bits;

  assign cmd_bits = cmd;

  aau_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  aau_datapath #(
    .FRACTION_BITS   (FRACTION_BITS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_write_en        (cfg_write_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_current_cost     (in_current_cost),
    .in_previous_cost    (in_previous_cost),
    .in_random_value     (in_random_value),
    .cmd                 (cmd),
    .status              (status),
    .out_accepted        (out_accepted),
    .out_temperature_out (out_temperature_out)
  );

  // a pending result is never overwritten
  `AAU_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid || out_ready)
  // at most one datapath command per cycle
  `AAU_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd_bits))
  // an input transfer is evaluated in the next cycle
  `AAU_ASSERT_NXT(a_accept_eval, in_valid && in_ready, cmd.eval && !in_ready)

endmodule

// ----- verif/anneal_acceptance_unit_top_tb.sv -----
module anneal_acceptance_unit_top_tb;
  import aau_pkg::*;

  localparam int unsigned FRAC_BITS     = 8;
  localparam int unsigned EXP_DEPTH     = 256;
  localparam int unsigned RANDOM_ITEMS  = 1500;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned MAX_GAP       = 16;
  localparam int          RUN_LIMIT     = 5_000_000;

  localparam logic [DATA_W-1:0]      ONE_Q        = 32'd1 << FRAC_BITS;
  localparam logic [DATA_W-1:0]      ALL_ONES     = 32'hFFFF_FFFF;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7  = 3'd7;

  typedef struct {
    logic              accepted;
    logic [DATA_W-1:0] temperature;
  } decision_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [DATA_W-1:0]      cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [DATA_W-1:0]      in_current_cost;
  logic [DATA_W-1:0]      in_previous_cost;
  logic [RND_W-1:0]       in_random_value;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_accepted;
  logic [DATA_W-1:0]      out_temperature_out;

  // acceptance model state
  mode_t             policy;
  logic [DATA_W-1:0] start_temp;
  logic [COOL_W-1:0] cool_factor;
  logic [HEAT_W-1:0] heat_factor;
  logic [DATA_W-1:0] temp_cap;
  logic [DATA_W-1:0] decay_step;
  logic [DATA_W-1:0] temp_now;
  logic [PROB_W-1:0] exp_tab [EXP_DEPTH];

  decision_t   decision_q [$];
  int unsigned mismatch_count;
  bit          send_quiet;
  bit          recv_quiet;

  anneal_acceptance_unit_top #(
    .FRACTION_BITS  (FRAC_BITS),
    .EXP_TABLE_DEPTH(EXP_DEPTH)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_current_cost    (in_current_cost),
    .in_previous_cost   (in_previous_cost),
    .in_random_value    (in_random_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accepted       (out_accepted),
    .out_temperature_out(out_temperature_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // exp(-x) table in Q1.16, stepped in Q30 by a truncated Taylor factor
  function automatic void build_exp_table();
    logic [63:0] a, sum, term, e;
    a    = (64'(EXP_SPAN) << 30) / EXP_DEPTH;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    e    = 64'd1 << 30;
    for (int unsigned n = 1; n <= 16; n++) begin
      term = ((term * a) >> 30) / n;
      if (n[0]) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    for (int unsigned i = 0; i < EXP_DEPTH; i++) begin
      exp_tab[i] = PROB_W'((e + (64'd1 << 13)) >> 14);
      e = (e * sum + (64'd1 << 29)) >> 30;
    end
  endfunction

  function automatic void reset_model();
    policy      = MODE_ANNEAL;
    start_temp  = RST_INITIAL_TEMP;
    cool_factor = RST_COOLING;
    heat_factor = RST_HEATING;
    temp_cap    = RST_MAX_TEMP;
    decay_step  = RST_DELUGE_DECAY;
    temp_now    = RST_INITIAL_TEMP;
  endfunction

  function automatic void apply_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [DATA_W-1:0] data);
    case (idx)
      REG_POLICY_MODE: begin
        policy = mode_t'(data[1:0]);
      end
      REG_INITIAL_TEMP: begin
        start_temp = data;
        temp_now   = data;
      end
      REG_COOLING: begin
        cool_factor = data[COOL_W-1:0];
      end
      REG_HEATING: begin
        heat_factor = data[HEAT_W-1:0];
      end
      REG_MAX_TEMP: begin
        temp_cap = data;
      end
      REG_DELUGE_DECAY: begin
        decay_step = data;
      end
      default: begin
      end
    endcase
  endfunction

  // truncated Q.16 product, saturating at 32 bits
  function automatic logic [DATA_W-1:0] scale_q16(input logic [DATA_W-1:0] t,
                                                  input logic [HEAT_W-1:0] f);
    logic [63:0] p;
    p = ({32'd0, t} * {40'd0, f}) >> 16;
    return (p > {32'd0, ALL_ONES}) ? ALL_ONES : p[DATA_W-1:0];
  endfunction

  function automatic decision_t next_decision(input logic [DATA_W-1:0] cur,
                                              input logic [DATA_W-1:0] prev,
                                              input logic [RND_W-1:0]  rnd);
    decision_t         d;
    logic [DATA_W-1:0] t;
    logic [63:0]       delta;
    logic [63:0]       idx;
    logic [PROB_W-1:0] prob;
    longint            rise;
    longint            tl;
    rise = longint'(cur) - longint'(prev);
    tl   = longint'(temp_now);
    case (policy)
      MODE_ANNEAL: begin
        if (temp_now == '0) begin
          // reload from the start value, at least 1.0, floor of one lsb
          t = (start_temp > ONE_Q) ? start_temp : ONE_Q;
          d.accepted = (cur <= prev);
          t = scale_q16(t, HEAT_W'(cool_factor));
          temp_now = (t != '0) ? t : 32'd1;
        end else begin
          if (cur <= prev) begin
            d.accepted = 1'b1;
          end else begin
            delta = {32'd0, cur} - {32'd0, prev};
            idx   = (delta * EXP_DEPTH) / ({32'd0, temp_now} * EXP_SPAN);
            prob  = (idx < EXP_DEPTH) ? exp_tab[idx] : '0;
            d.accepted = ({1'b0, rnd} < prob);
          end
          temp_now = scale_q16(temp_now, HEAT_W'(cool_factor));
        end
      end
      MODE_THRESHOLD: begin
        d.accepted = (rise <= tl);
        temp_now = scale_q16(temp_now, HEAT_W'(cool_factor));
      end
      MODE_OLD_BACHELOR: begin
        d.accepted = (rise < tl);
        if (d.accepted) begin
          temp_now = scale_q16(temp_now, HEAT_W'(cool_factor));
        end else begin
          t = scale_q16(temp_now, heat_factor);
          temp_now = (t < temp_cap) ? t : temp_cap;
        end
      end
      default: begin
        d.accepted = (rise < tl);
        if (d.accepted) begin
          temp_now = (temp_now > decay_step) ? temp_now - decay_step : '0;
        end
      end
    endcase
    d.temperature = temp_now;
    return d;
  endfunction

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [DATA_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    apply_cfg(idx, data);
    @(posedge clk);
  endtask

  task automatic send_item(input logic [DATA_W-1:0] cur,
                           input logic [DATA_W-1:0] prev,
                           input logic [RND_W-1:0]  rnd);
    int unsigned gap;
    gap = draw_gap(send_quiet);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_current_cost  <= cur;
    in_previous_cost <= prev;
    in_random_value  <= rnd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decision_q.push_back(next_decision(cur, prev, rnd));
  endtask

  // drain all results, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (decision_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report(input string what, input logic [DATA_W-1:0] want,
                        input logic [DATA_W-1:0] got);
    $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  initial begin
    decision_t   want;
    int unsigned ready_hold;
    ready_hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (decision_q.size() == 0) begin
          report("result with none pending, temperature", '0, out_temperature_out);
        end else begin
          want = decision_q.pop_front();
          if (out_accepted !== want.accepted) begin
            report("accepted", DATA_W'(want.accepted), DATA_W'(out_accepted));
          end
          if (out_temperature_out !== want.temperature) begin
            report("temperature_out", want.temperature, out_temperature_out);
          end
        end
        ready_hold = draw_gap(recv_quiet);
        if (ready_hold != 0) begin
          out_ready <= 1'b0;
        end
      end else if (!out_ready) begin
        if (ready_hold != 0) begin
          ready_hold--;
        end
        if (ready_hold == 0) begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  task automatic test_default_anneal();
    settle();
    send_item(32'd0, 32'd0, 16'd0);
    send_item(ALL_ONES, 32'd0, 16'hFFFF);
    send_item(32'd0, ALL_ONES, 16'd0);
    send_item(32'd100, 32'd0, 16'd0);
    send_item(32'd100, 32'd0, 16'hFFFF);
    send_item(32'd160000, 32'd0, 16'h0100);
  endtask

  task automatic test_zero_temperature();
    settle();
    cfg_write(REG_INITIAL_TEMP, 32'd0);
    send_item(32'd5, 32'd3, 16'd0);
    send_item(32'd3, 32'd5, 16'd0);
    settle();
    cfg_write(REG_COOLING, 32'd0);
    cfg_write(REG_INITIAL_TEMP, 32'd0);
    send_item(32'd7, 32'd7, 16'd0);
    send_item(32'd8, 32'd7, 16'd0);
    send_item(32'd0, 32'd0, 16'd0);
    settle();
    cfg_write(REG_COOLING, DATA_W'(RST_COOLING));
  endtask

  task automatic test_threshold();
    settle();
    cfg_write(REG_POLICY_MODE, {30'h3FFF_FFFF, MODE_THRESHOLD});
    cfg_write(REG_INITIAL_TEMP, 32'd1000);
    cfg_write(REG_COOLING, 32'd65536);
    send_item(32'd2000, 32'd1000, 16'hFFFF);
    send_item(32'd2001, 32'd1000, 16'd0);
    send_item(32'd0, ALL_ONES, 16'hFFFF);
    settle();
    // cooling factor above 1.0 saturates
    cfg_write(REG_COOLING, ALL_ONES);
    cfg_write(REG_INITIAL_TEMP, ALL_ONES);
    send_item(32'd0, 32'd0, 16'd0);
  endtask

  task automatic test_old_bachelor();
    settle();
    cfg_write(REG_POLICY_MODE, {30'd0, MODE_OLD_BACHELOR});
    cfg_write(REG_COOLING, DATA_W'(RST_COOLING));
    cfg_write(REG_INITIAL_TEMP, 32'd1000);
    cfg_write(REG_HEATING, ALL_ONES);
    cfg_write(REG_MAX_TEMP, 32'd5000);
    send_item(32'd2000, 32'd1000, 16'd0);
    send_item(32'd1000, 32'd1000, 16'd0);
    settle();
    cfg_write(REG_MAX_TEMP, 32'd0);
    send_item(ALL_ONES, 32'd0, 16'd0);
    send_item(32'd0, 32'd1, 16'd0);
  endtask

  task automatic test_deluge();
    settle();
    cfg_write(REG_POLICY_MODE, {30'd0, MODE_DELUGE});
    cfg_write(REG_INITIAL_TEMP, 32'd300);
    cfg_write(REG_DELUGE_DECAY, 32'd256);
    send_item(32'd1, 32'd0, 16'd0);
    send_item(32'd45, 32'd0, 16'd0);
    settle();
    cfg_write(REG_DELUGE_DECAY, ALL_ONES);
    send_item(32'd0, 32'd0, 16'd0);
    send_item(32'd0, 32'd0, 16'd0);
    send_item(32'd0, 32'd5, 16'd0);
  endtask

  task automatic test_spare_registers();
    settle();
    cfg_write(REG_SPARE_6, ALL_ONES);
    cfg_write(REG_SPARE_7, ALL_ONES);
    send_item(32'd0, 32'd1, 16'hFFFF);
  endtask

  task automatic random_config(input bit all);
    logic [DATA_W-1:0] v;
    if (all || $urandom_range(0, 9) < 7) begin
      cfg_write(REG_POLICY_MODE, {30'($urandom), 2'($urandom_range(0, 3))});
    end
    if (all || $urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 5))
        0: v = 32'd0;
        1: v = ONE_Q;
        2: v = $urandom_range(1, 4096);
        3: v = $urandom_range(4096, 2000000);
        4: v = $urandom;
        default: v = ALL_ONES;
      endcase
      cfg_write(REG_INITIAL_TEMP, v);
    end
    if (all || $urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 5))
        0: v = 32'd0;
        1: v = 32'd65536;
        2: v = 32'h1FFFF;
        default: v = $urandom_range(60000, 65536);
      endcase
      cfg_write(REG_COOLING, {15'($urandom), v[COOL_W-1:0]});
    end
    if (all || $urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 4))
        0: v = 32'd0;
        1: v = 32'hFF_FFFF;
        2: v = $urandom_range(0, 32'hFF_FFFF);
        default: v = $urandom_range(65536, 90000);
      endcase
      cfg_write(REG_HEATING, {8'($urandom), v[HEAT_W-1:0]});
    end
    if (all || $urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 3))
        0: v = 32'd0;
        1: v = ALL_ONES;
        2: v = $urandom;
        default: v = $urandom_range(1000, 10000000);
      endcase
      cfg_write(REG_MAX_TEMP, v);
    end
    if (all || $urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 3))
        0: v = 32'd0;
        1: v = ALL_ONES;
        2: v = $urandom;
        default: v = $urandom_range(1, 1000);
      endcase
      cfg_write(REG_DELUGE_DECAY, v);
    end
    if ($urandom_range(0, 9) == 0) begin
      cfg_write($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
    end
  endtask

  task automatic send_random_item();
    logic [DATA_W-1:0] cur, prev, d;
    logic [RND_W-1:0]  rnd;
    logic [63:0]       lim;
    prev = $urandom;
    cur  = $urandom;
    case ($urandom_range(0, 7))
      0: begin
      end
      1: begin
        cur = prev;
      end
      2: begin
        cur = $urandom_range(0, prev);
      end
      3: begin
        cur  = $urandom_range(0, 1) ? ALL_ONES : 32'd0;
        prev = $urandom_range(0, 1) ? ALL_ONES : 32'd0;
      end
      7: begin
        // rise right at the temperature
        lim = {32'd0, temp_now} + $urandom_range(0, 2);
        lim = (lim == 0) ? 64'd0 : lim - 1;
        d = (lim > {32'd0, ALL_ONES}) ? ALL_ONES : lim[DATA_W-1:0];
        prev = $urandom_range(0, ALL_ONES - d);
        cur  = prev + d;
      end
      default: begin
        // rise spread over the probability table and a little beyond
        lim = {32'd0, temp_now} * EXP_SPAN + {32'd0, temp_now};
        if (lim == 0) begin
          lim = 64'(EXP_SPAN);
        end
        if (lim > {32'd0, ALL_ONES}) begin
          lim = {32'd0, ALL_ONES};
        end
        d = $urandom_range(0, lim[DATA_W-1:0]);
        prev = $urandom_range(0, ALL_ONES - d);
        cur  = prev + d;
      end
    endcase
    case ($urandom_range(0, 7))
      0: rnd = '0;
      1: rnd = '1;
      default: rnd = $urandom_range(0, 65535);
    endcase
    send_item(cur, prev, rnd);
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned phase_len;
    bit          first;
    sent  = 0;
    first = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      settle();
      random_config(first);
      first      = 1'b0;
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      phase_len  = $urandom_range(40, 120);
      repeat (phase_len) send_random_item();
      sent += phase_len;
    end
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  initial begin
    mismatch_count = 0;
    send_quiet     = 1'b0;
    recv_quiet     = 1'b0;
    rst_n            <= 1'b0;
    cfg_write_en     <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    in_current_cost  <= '0;
    in_previous_cost <= '0;
    in_random_value  <= '0;
    build_exp_table();
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_default_anneal();
    test_zero_temperature();
    test_threshold();
    test_old_bachelor();
    test_deluge();
    test_spare_registers();
    test_random();
    settle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/aau_pkg.sv
design/aau_ctrl.sv
design/aau_datapath.sv
design/anneal_acceptance_unit_top.sv
verif/anneal_acceptance_unit_top_tb.sv
